FILE: rtl/core/nrhp_pkg.sv
// ----------------------------------------------------------------------------
// NDEF record header parser package
// Shared types and constants for the record parser core and its parse step.
// ----------------------------------------------------------------------------
package nrhp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned LCOUNT_W  = 2;

  localparam int unsigned FLAG_MB_BIT = 7;
  localparam int unsigned FLAG_ME_BIT = 6;
  localparam int unsigned FLAG_SR_BIT = 4;

  localparam logic [LCOUNT_W-1:0] LEN_BYTES_LAST = 2'd3;

  typedef enum logic [2:0] {
    PH_FLAGS   = 3'd0,
    PH_TYPELEN = 3'd1,
    PH_PAYLEN  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_FLAGS   = 3'd0,
    ROLE_TYPELEN = 3'd1,
    ROLE_PAYLEN  = 3'd2,
    ROLE_TYPE    = 3'd3,
    ROLE_PAYLOAD = 3'd4
  } byte_role_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              buffer_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        byte_role;
    logic [BYTE_W-1:0] out_byte;
    logic              message_begin;
    logic              message_end;
    logic [BYTE_W-1:0] type_length;
    logic [LEN_W-1:0]  payload_length;
    logic              header_ready;
    logic              record_last;
    logic              truncated;
  } out_item_t;

  typedef struct packed {
    phase_t              phase;
    logic [BYTE_W-1:0]   flag_bits;
    logic [BYTE_W-1:0]   type_size;
    logic [LEN_W-1:0]    payload_size;
    logic [LCOUNT_W-1:0] len_count;
    logic [LEN_W-1:0]    bytes_remaining;
  } parse_state_t;

endpackage

FILE: rtl/core/nrhp_parse.sv
// ----------------------------------------------------------------------------
// NDEF record parse step
// Classifies one byte against the current parser state and gives the next
// state together with the result of the byte.
// ----------------------------------------------------------------------------
module nrhp_parse (
  input  nrhp_pkg::parse_state_t st,
  input  nrhp_pkg::in_item_t     item,
  output nrhp_pkg::parse_state_t st_nxt,
  output nrhp_pkg::out_item_t    res
);

  logic                        short_rec;
  logic                        len_done;
  logic [nrhp_pkg::LEN_W-1:0]  pl_new;
  logic [nrhp_pkg::LEN_W-1:0]  rem_dec;
  logic                        rem_zero;
  logic                        rec_last;

  assign short_rec = st.flag_bits[nrhp_pkg::FLAG_SR_BIT];
  assign len_done  = short_rec || (st.len_count == nrhp_pkg::LEN_BYTES_LAST);
  assign pl_new    = short_rec ? {{(nrhp_pkg::LEN_W-nrhp_pkg::BYTE_W){1'b0}}, item.in_byte}
                               : {st.payload_size[nrhp_pkg::LEN_W-nrhp_pkg::BYTE_W-1:0],
                                  item.in_byte};
  assign rem_dec   = (st.bytes_remaining != '0) ? st.bytes_remaining - 1'b1 : '0;
  assign rem_zero  = (rem_dec == '0);

  always_comb begin
    case (st.phase)
      nrhp_pkg::PH_PAYLEN: begin
        rec_last = len_done && (st.type_size == '0) && (pl_new == '0);
      end
      nrhp_pkg::PH_TYPE: begin
        rec_last = rem_zero && (st.payload_size == '0);
      end
      nrhp_pkg::PH_PAYLOAD: begin
        rec_last = rem_zero;
      end
      default: begin
        rec_last = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st;
    case (st.phase)
      nrhp_pkg::PH_TYPELEN: begin
        st_nxt.type_size = item.in_byte;
        st_nxt.phase     = nrhp_pkg::PH_PAYLEN;
      end
      nrhp_pkg::PH_PAYLEN: begin
        st_nxt.payload_size = pl_new;
        if (!short_rec) begin
          st_nxt.len_count = len_done ? '0 : st.len_count + 1'b1;
        end
        if (len_done) begin
          if (st.type_size != '0) begin
            st_nxt.bytes_remaining = {{(nrhp_pkg::LEN_W-nrhp_pkg::BYTE_W){1'b0}}, st.type_size};
            st_nxt.phase           = nrhp_pkg::PH_TYPE;
          end else if (pl_new != '0) begin
            st_nxt.bytes_remaining = pl_new;
            st_nxt.phase           = nrhp_pkg::PH_PAYLOAD;
          end else begin
            st_nxt.phase = nrhp_pkg::PH_FLAGS;
          end
        end
      end
      nrhp_pkg::PH_TYPE: begin
        st_nxt.bytes_remaining = rem_dec;
        if (rem_zero) begin
          if (st.payload_size != '0) begin
            st_nxt.bytes_remaining = st.payload_size;
            st_nxt.phase           = nrhp_pkg::PH_PAYLOAD;
          end else begin
            st_nxt.phase = nrhp_pkg::PH_FLAGS;
          end
        end
      end
      nrhp_pkg::PH_PAYLOAD: begin
        st_nxt.bytes_remaining = rem_dec;
        if (rem_zero) begin
          st_nxt.phase = nrhp_pkg::PH_FLAGS;
        end
      end
      default: begin
        st_nxt.flag_bits       = item.in_byte;
        st_nxt.type_size       = '0;
        st_nxt.payload_size    = '0;
        st_nxt.len_count       = '0;
        st_nxt.bytes_remaining = '0;
        st_nxt.phase           = nrhp_pkg::PH_TYPELEN;
      end
    endcase
    if (item.buffer_last && !rec_last) begin
      st_nxt.phase = nrhp_pkg::PH_FLAGS;
    end
  end

  // Result of the byte.
  always_comb begin
    res                = '0;
    res.out_byte       = item.in_byte;
    res.message_begin  = st.flag_bits[nrhp_pkg::FLAG_MB_BIT];
    res.message_end    = st.flag_bits[nrhp_pkg::FLAG_ME_BIT];
    res.type_length    = st.type_size;
    res.record_last    = rec_last;
    res.truncated      = item.buffer_last && !rec_last;
    case (st.phase)
      nrhp_pkg::PH_TYPELEN: begin
        res.byte_role   = nrhp_pkg::ROLE_TYPELEN;
        res.type_length = item.in_byte;
      end
      nrhp_pkg::PH_PAYLEN: begin
        res.byte_role      = nrhp_pkg::ROLE_PAYLEN;
        res.header_ready   = len_done;
        res.payload_length = len_done ? pl_new : '0;
      end
      nrhp_pkg::PH_TYPE: begin
        res.byte_role      = nrhp_pkg::ROLE_TYPE;
        res.header_ready   = 1'b1;
        res.payload_length = st.payload_size;
      end
      nrhp_pkg::PH_PAYLOAD: begin
        res.byte_role      = nrhp_pkg::ROLE_PAYLOAD;
        res.header_ready   = 1'b1;
        res.payload_length = st.payload_size;
      end
      default: begin
        res.byte_role     = nrhp_pkg::ROLE_FLAGS;
        res.message_begin = item.in_byte[nrhp_pkg::FLAG_MB_BIT];
        res.message_end   = item.in_byte[nrhp_pkg::FLAG_ME_BIT];
        res.type_length   = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/ndef_record_header_parser_core.sv
// ----------------------------------------------------------------------------
// NDEF record header parser core
// Takes one byte of an NDEF record stream per transfer and returns one result
// per byte: its role in the record, the message-begin and message-end bits,
// the type and payload lengths and flags for the record's last byte and for a
// buffer that ends inside a record. A complete record is followed by the flags
// byte of the next one. One byte is taken in every cycle unless in_stall is
// high; the byte's result is offered from the result register, after the byte
// has passed the input register. While a result waits for the receiver, the
// input register holds one further byte and the input stalls with the output.
// ----------------------------------------------------------------------------
module ndef_record_header_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nrhp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nrhp_pkg::out_item_t  out_data
);

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  nrhp_pkg::in_item_t     s1_item_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  nrhp_pkg::out_item_t    out_item_r;
  nrhp_pkg::parse_state_t state_r;
  nrhp_pkg::parse_state_t state_nxt;
  nrhp_pkg::out_item_t    res;
  logic                   in_take;
  logic                   advance;

  nrhp_parse u_parse (
    .st     (state_r),
    .item   (s1_item_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  assign advance       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !advance;
  assign in_take       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: nrhp_pkg::PH_FLAGS, default: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

endmodule
